// File: rtl/core/bsfr_pkg.sv
package bsfr_pkg;

   localparam int DATA_W    = 8;
   localparam int INDEX_W   = 6;
   localparam int LENGTH_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam int MAX_PACKET_DEFAULT = 32;

   localparam logic [DATA_W-1:0] START_BYTE_RESET = 8'd126;
   localparam logic [DATA_W-1:0] END_BYTE_RESET   = 8'd125;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE   = 1'd1;

   typedef enum logic [1:0] {
      STATUS_DATA     = 2'd0,
      STATUS_ABORT    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       store;
      logic       clr_count;
      logic       drain_start;
      logic       drain_next;
      logic       load_data;
      logic       load_status;
      status_type status_code;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic start_hit;
      logic end_hit;
      logic count_full;
      logic count_zero;
      logic drain_last;
      logic out_valid;
      logic out_free;
   } dp_sts_type;

endpackage

// File: rtl/core/bsfr_ram.sv
module bsfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bsfr_dpath.sv
module bsfr_dpath #(
   parameter int MAX_PACKET = bsfr_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bsfr_pkg::ctrl_cmd_type           cmd,
   output bsfr_pkg::dp_sts_type             sts,
   input  logic [bsfr_pkg::DATA_W-1:0]      req_rx_byte,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [bsfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsfr_pkg::DATA_W-1:0]      csr_wdata,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bsfr_pkg::DATA_W-1:0]      rsp_data,
   output logic [bsfr_pkg::INDEX_W-1:0]     rsp_index,
   output logic [bsfr_pkg::LENGTH_W-1:0]    rsp_length,
   output logic                             rsp_last,
   output logic [1:0]                       rsp_status
);

   localparam int AW = $clog2(MAX_PACKET);
   localparam int IW = bsfr_pkg::INDEX_W;
   localparam int LW = bsfr_pkg::LENGTH_W;
   localparam int DW = bsfr_pkg::DATA_W;

   logic [DW-1:0] start_ff;
   logic [DW-1:0] end_ff;
   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [DW-1:0] ram_rd_data;
   logic          drain_last;
   logic          out_free;

   logic                     rsp_valid_ff;
   logic [DW-1:0]            rsp_data_ff;
   logic [IW-1:0]            rsp_index_ff;
   logic [LW-1:0]            rsp_length_ff;
   logic                     rsp_last_ff;
   bsfr_pkg::status_type     rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= bsfr_pkg::START_BYTE_RESET;
         end_ff   <= bsfr_pkg::END_BYTE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bsfr_pkg::CSR_START_BYTE: start_ff <= csr_wdata;
            bsfr_pkg::CSR_END_BYTE:   end_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clear wins over the increment on overflow
   always_comb begin
      count_in = count_ff;
      if (cmd.clr_count) begin
         count_in = '0;
      end else if (cmd.store) begin
         count_in = count_ff + AW'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.drain_start) begin
         idx_in = '0;
      end else if (cmd.drain_next) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   bsfr_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_PACKET)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (count_ff),
      .wr_data (req_rx_byte),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign drain_last = (idx_ff + AW'(1)) == count_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_status || cmd.load_data) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_status) begin
         rsp_data_ff   <= '0;
         rsp_index_ff  <= '0;
         rsp_length_ff <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= cmd.status_code;
      end else if (cmd.load_data) begin
         rsp_data_ff   <= ram_rd_data;
         rsp_index_ff  <= IW'(idx_ff);
         rsp_length_ff <= LW'(count_ff);
         rsp_last_ff   <= drain_last;
         rsp_status_ff <= bsfr_pkg::STATUS_DATA;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   assign sts.start_hit  = req_rx_byte == start_ff;
   assign sts.end_hit    = req_rx_byte == end_ff;
   assign sts.count_full = count_ff == AW'(MAX_PACKET - 1);
   assign sts.count_zero = count_ff == '0;
   assign sts.drain_last = drain_last;
   assign sts.out_valid  = rsp_valid_ff;
   assign sts.out_free   = out_free;

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.load_status || cmd.load_data) |-> out_free)
      else $error("result loaded over a word still waiting");

   a_status_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != bsfr_pkg::STATUS_DATA) |->
         (rsp_last_ff && rsp_data_ff == '0 && rsp_length_ff == '0))
      else $error("status word carries packet fields");

   a_drain_nonempty : assert property (@(posedge clock) disable iff (reset)
      cmd.load_data |-> (count_ff != '0 && idx_ff < count_ff))
      else $error("drain read past the stored bytes");

   a_store_room : assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (!cmd.load_data && count_ff <= AW'(MAX_PACKET - 1)))
      else $error("store outside the buffer");

endmodule

// File: rtl/core/bsfr_ctrl.sv
module bsfr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bsfr_pkg::dp_sts_type    sts,
   output bsfr_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ID,
      ST_BODY,
      ST_ESC,
      ST_ERR,
      ST_ERR_ESC,
      ST_DRAIN_RD,
      ST_DRAIN_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      draining;
   logic      accept;

   assign draining  = state_ff == ST_DRAIN_RD || state_ff == ST_DRAIN_OUT;
   assign req_stall = draining || sts.out_valid;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status_code = bsfr_pkg::STATUS_DATA;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && sts.start_hit) begin
               cmd.clr_count = 1'b1;
               state_in      = ST_ID;
            end
         end
         ST_ID, ST_BODY: begin
            if (accept) begin
               if (state_ff == ST_BODY && sts.start_hit) begin
                  state_in = ST_ESC;
               end else begin
                  cmd.store = 1'b1;
                  state_in  = ST_BODY;
                  // drop the frame once the buffer fills
                  if (sts.count_full) begin
                     cmd.clr_count   = 1'b1;
                     cmd.load_status = 1'b1;
                     cmd.status_code = bsfr_pkg::STATUS_OVERFLOW;
                     state_in        = ST_IDLE;
                  end
               end
            end
         end
         ST_ESC: begin
            if (accept) begin
               if (sts.start_hit) begin
                  cmd.store = 1'b1;
                  state_in  = ST_BODY;
                  if (sts.count_full) begin
                     cmd.clr_count   = 1'b1;
                     cmd.load_status = 1'b1;
                     cmd.status_code = bsfr_pkg::STATUS_OVERFLOW;
                     state_in        = ST_IDLE;
                  end
               end else if (sts.end_hit) begin
                  if (sts.count_zero) begin
                     state_in = ST_IDLE;
                  end else begin
                     cmd.drain_start = 1'b1;
                     state_in        = ST_DRAIN_RD;
                  end
               end else begin
                  cmd.load_status = 1'b1;
                  cmd.status_code = bsfr_pkg::STATUS_ABORT;
                  state_in        = ST_ERR;
               end
            end
         end
         ST_ERR: begin
            if (accept && sts.start_hit) begin
               state_in = ST_ERR_ESC;
            end
         end
         ST_ERR_ESC: begin
            if (accept) begin
               state_in = sts.end_hit ? ST_IDLE : ST_ERR;
            end
         end
         ST_DRAIN_RD: begin
            // read data lands next cycle
            state_in = ST_DRAIN_OUT;
         end
         ST_DRAIN_OUT: begin
            if (sts.out_free) begin
               cmd.load_data = 1'b1;
               if (sts.drain_last) begin
                  cmd.clr_count = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.drain_next = 1'b1;
                  state_in       = ST_DRAIN_RD;
               end
            end
         end
         default: state_in = ST_ERR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_accept_in_drain : assert property (@(posedge clock) disable iff (reset)
      draining |-> !accept)
      else $error("word accepted during drain");

   a_drain_ends_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN_OUT && sts.out_free && sts.drain_last) |=>
         (state_ff == ST_IDLE))
      else $error("drain did not return to idle");

endmodule

// File: rtl/core/byte_stuffed_frame_receiver.sv
// Channel  Dir  Handshake              Payload
// req      in   req_valid/req_stall    req_rx_byte
// rsp      out  rsp_valid/rsp_stall    rsp_data, rsp_index, rsp_length, rsp_last, rsp_status
// csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// A received byte is taken while req_stall is low; a byte that raises a status word
// holds off the next byte until that word leaves the output register.
// A closed packet drains byte by byte, each read from the registered port of the packet
// store in ST_DRAIN_RD and sent in ST_DRAIN_OUT; no byte is taken while draining.
// Reset is synchronous; the packet store needs no clearing pass.
// A stall on rsp holds the output register and, through it, the req channel.
module byte_stuffed_frame_receiver #(
   parameter int MAX_PACKET = bsfr_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [bsfr_pkg::DATA_W-1:0]      req_rx_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bsfr_pkg::DATA_W-1:0]      rsp_data,
   output logic [bsfr_pkg::INDEX_W-1:0]     rsp_index,
   output logic [bsfr_pkg::LENGTH_W-1:0]    rsp_length,
   output logic                             rsp_last,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bsfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsfr_pkg::DATA_W-1:0]      csr_wdata
);

   bsfr_pkg::ctrl_cmd_type cmd;
   bsfr_pkg::dp_sts_type   sts;

   assign csr_ready = 1'b1;

   bsfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bsfr_dpath #(
      .MAX_PACKET (MAX_PACKET)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .rsp_index   (rsp_index),
      .rsp_length  (rsp_length),
      .rsp_last    (rsp_last),
      .rsp_status  (rsp_status)
   );

endmodule
